// File: hdl/ttpq_pkg.sv
`default_nettype none
package ttpq_pkg;

  localparam int ACTOR_W = 10;
  localparam int DELAY_W = 16;
  localparam int TIME_W  = 32;

  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_REMOVE = 2'd1;
  localparam logic [1:0] CMD_POP    = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_EMPTY     = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;
  localparam logic [1:0] ST_NOT_FOUND = 2'd3;

  typedef struct packed {
    logic [1:0]         command;
    logic [ACTOR_W-1:0] actor_id;
    logic [DELAY_W-1:0] delay;
  } req_t;

  typedef struct packed {
    logic [ACTOR_W-1:0] popped_actor;
    logic               popped_valid;
    logic [1:0]         status;
  } rsp_t;

endpackage
`default_nettype wire

// File: hdl/ttpq_chan_if.sv
`default_nettype none
interface ttpq_chan_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

// File: hdl/timed_turn_priority_queue.sv
// Timed turn priority queue.
// req (sink): one word per command: insert, remove or pop, with actor id and
//   delay. rsp (source): one word per command: popped actor, popped flag and
//   status. Both channels move a word when valid and ready are high at a clock.
// Entries live in a single-port-read, single-port-write memory of CAPACITY
// rows, kept sorted front first. One sequencer walks it row by row, each
// row a registered read, then compare/subtract and write. An insert that
// must rebase the due times first walks every row to subtract the start
// time. Full, empty, unknown commands and an insert into an empty queue
// finish at dispatch with no walk. req.ready is high only while the
// sequencer is idle, so no new command is taken while one is in progress.
// A finished word sits in the rsp register; the block may accept the next
// command meanwhile, and holds that command's result until rsp is taken,
// so a stalled receiver just holds the sequencer at its last step.
// Reset (rst, synchronous) empties the queue, clears the start time and
// drops any pending response; memory contents are not cleared since only
// rows below the entry count are ever read.
`default_nettype none
module timed_turn_priority_queue #(
  parameter int CAPACITY     = 64,
  parameter int REBASE_LIMIT = 2000000000
) (
  input  wire logic clk,
  input  wire logic rst,
  ttpq_chan_if.sink   req,
  ttpq_chan_if.source rsp
);

  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int AW    = ttpq_pkg::ACTOR_W;
  localparam int TW    = ttpq_pkg::TIME_W;

  // sequencer states
  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_DISP     = 4'd1;
  localparam logic [3:0] S_REB_RD   = 4'd2;
  localparam logic [3:0] S_REB_WR   = 4'd3;
  localparam logic [3:0] S_SRCH_RD  = 4'd4;
  localparam logic [3:0] S_SRCH_CHK = 4'd5;
  localparam logic [3:0] S_SHIFT_RD = 4'd6;
  localparam logic [3:0] S_SHIFT_WR = 4'd7;
  localparam logic [3:0] S_RMV_RD   = 4'd8;
  localparam logic [3:0] S_RMV_CHK  = 4'd9;
  localparam logic [3:0] S_DROP_RD  = 4'd10;
  localparam logic [3:0] S_DROP_WR  = 4'd11;
  localparam logic [3:0] S_POP_RD   = 4'd12;
  localparam logic [3:0] S_POP_CHK  = 4'd13;
  localparam logic [3:0] S_FIN      = 4'd14;

  logic [3:0]       state;
  logic [CNT_W-1:0] count;
  logic [TW-1:0]    base;
  logic [TW-1:0]    when;
  logic [CNT_W-1:0] ptr;
  ttpq_pkg::req_t   cur;
  ttpq_pkg::rsp_t   res;
  ttpq_pkg::rsp_t   out;
  logic             out_valid;
  logic [1:0]       disp_status;

  // carry entry for the insert shift
  logic [AW-1:0]    carry_actor;
  logic [TW-1:0]    carry_due;

  // entry memory
  logic [AW-1:0]    actor_mem [CAPACITY];
  logic [TW-1:0]    due_mem   [CAPACITY];
  logic [AW-1:0]    rd_actor;
  logic [TW-1:0]    rd_due;
  logic [IDX_W-1:0] rd_addr;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  logic [AW-1:0]    wr_actor;
  logic [TW-1:0]    wr_due;

  logic             at_end;   // ptr has reached the entry count
  logic             at_last;  // ptr is the last valid row
  logic             rsp_free;

  assign rd_addr  = ptr[IDX_W-1:0];
  assign at_end   = (ptr == count);
  assign at_last  = ((ptr + CNT_W'(1)) == count);
  assign rsp_free = !out_valid || rsp.ready;

  assign req.ready   = (state == S_IDLE);
  assign rsp.valid   = out_valid;
  assign rsp.payload = out;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      actor_mem[wr_addr] <= wr_actor;
      due_mem[wr_addr]   <= wr_due;
    end
    rd_actor <= actor_mem[rd_addr];
    rd_due   <= due_mem[rd_addr];
  end

  // status known at dispatch: full on insert, empty on remove and pop
  always_comb begin
    disp_status = ttpq_pkg::ST_OK;
    if (cur.command == ttpq_pkg::CMD_INSERT && count >= CNT_W'(CAPACITY)) begin
      disp_status = ttpq_pkg::ST_FULL;
    end else if ((cur.command == ttpq_pkg::CMD_REMOVE || cur.command == ttpq_pkg::CMD_POP)
                 && count == '0) begin
      disp_status = ttpq_pkg::ST_EMPTY;
    end
  end

  // memory write port
  always_comb begin
    wr_en    = 1'b0;
    wr_addr  = ptr[IDX_W-1:0];
    wr_actor = cur.actor_id;
    wr_due   = when;
    unique case (state)
      S_DISP: begin
        if (cur.command == ttpq_pkg::CMD_INSERT && count == '0) begin
          wr_en   = 1'b1;
          wr_addr = '0;
          wr_due  = '0;
        end
      end
      S_REB_WR: begin
        wr_en    = 1'b1;
        wr_actor = rd_actor;
        wr_due   = rd_due - base;
      end
      S_SRCH_RD: wr_en = at_end;
      S_SRCH_CHK: wr_en = (rd_due > when);
      S_SHIFT_RD: begin
        wr_en    = at_end;
        wr_actor = carry_actor;
        wr_due   = carry_due;
      end
      S_SHIFT_WR: begin
        wr_en    = 1'b1;
        wr_actor = carry_actor;
        wr_due   = carry_due;
      end
      S_DROP_WR: begin
        wr_en    = 1'b1;
        wr_addr  = IDX_W'(ptr - CNT_W'(1));
        wr_actor = rd_actor;
        wr_due   = rd_due;
      end
      default: wr_en = 1'b0;
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      base      <= '0;
      out_valid <= 1'b0;
    end else begin
      // a new word may load in the same cycle the old one is taken
      if (state == S_FIN && rsp_free) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req.valid) begin
            cur   <= req.payload;
            state <= S_DISP;
          end
        end
        S_DISP: begin
          res <= '{popped_actor: '0, popped_valid: 1'b0, status: disp_status};
          priority case (cur.command)
            ttpq_pkg::CMD_INSERT: begin
              priority if (count == '0) begin
                base  <= '0;
                count <= CNT_W'(1);
                state <= S_FIN;
              end else if (count >= CNT_W'(CAPACITY)) begin
                state <= S_FIN;
              end else if (base > TW'(REBASE_LIMIT)) begin
                ptr   <= '0;
                state <= S_REB_RD;
              end else begin
                when  <= base + TW'(cur.delay);
                ptr   <= CNT_W'(1);
                state <= S_SRCH_RD;
              end
            end
            ttpq_pkg::CMD_REMOVE: begin
              ptr <= '0;
              if (count == '0) state <= S_FIN;
              else             state <= S_RMV_RD;
            end
            ttpq_pkg::CMD_POP: begin
              ptr <= '0;
              if (count == '0) state <= S_FIN;
              else             state <= S_POP_RD;
            end
            default: state <= S_FIN;
          endcase
        end
        S_REB_RD: state <= S_REB_WR;
        S_REB_WR: begin
          if (at_last) begin
            base  <= '0;
            when  <= TW'(cur.delay);
            ptr   <= CNT_W'(1);
            state <= S_SRCH_RD;
          end else begin
            ptr   <= ptr + CNT_W'(1);
            state <= S_REB_RD;
          end
        end
        S_SRCH_RD: begin
          if (at_end) begin
            count <= count + CNT_W'(1);
            state <= S_FIN;
          end else begin
            state <= S_SRCH_CHK;
          end
        end
        S_SRCH_CHK: begin
          ptr <= ptr + CNT_W'(1);
          if (rd_due <= when) begin
            state <= S_SRCH_RD;
          end else begin
            carry_actor <= rd_actor;
            carry_due   <= rd_due;
            state       <= S_SHIFT_RD;
          end
        end
        S_SHIFT_RD: begin
          if (at_end) begin
            count <= count + CNT_W'(1);
            state <= S_FIN;
          end else begin
            state <= S_SHIFT_WR;
          end
        end
        S_SHIFT_WR: begin
          carry_actor <= rd_actor;
          carry_due   <= rd_due;
          ptr         <= ptr + CNT_W'(1);
          state       <= S_SHIFT_RD;
        end
        S_RMV_RD: state <= S_RMV_CHK;
        S_RMV_CHK: begin
          ptr <= ptr + CNT_W'(1);
          priority if (rd_actor == cur.actor_id) begin
            state <= S_DROP_RD;
          end else if (at_last) begin
            res.status <= ttpq_pkg::ST_NOT_FOUND;
            state      <= S_FIN;
          end else begin
            state <= S_RMV_RD;
          end
        end
        S_DROP_RD: begin
          if (at_end) begin
            count <= count - CNT_W'(1);
            state <= S_FIN;
          end else begin
            state <= S_DROP_WR;
          end
        end
        S_DROP_WR: begin
          ptr   <= ptr + CNT_W'(1);
          state <= S_DROP_RD;
        end
        S_POP_RD: state <= S_POP_CHK;
        S_POP_CHK: begin
          res   <= '{popped_actor: rd_actor, popped_valid: 1'b1, status: ttpq_pkg::ST_OK};
          base  <= rd_due;
          ptr   <= CNT_W'(1);
          state <= S_DROP_RD;
        end
        S_FIN: begin
          if (rsp_free) begin
            out   <= res;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready |=> !req.ready)
    else $error("ready while a command is in flight");

  a_pop_ok: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.payload.popped_valid |-> rsp.payload.status == ttpq_pkg::ST_OK)
    else $error("popped word without ok status");

  a_walk_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_SRCH_CHK || state == S_RMV_CHK || state == S_DROP_WR) |-> ptr < count)
    else $error("walk pointer past last entry");
`endif

endmodule
`default_nettype wire

// File: verif/tb_timed_turn_priority_queue.sv
`default_nettype none
import ttpq_pkg::*;

// Tracks the turn queue the block should hold. It computes the response word
// each accepted command must produce and checks the words that come back in
// order.
class turn_queue_tracker #(int CAP = 64, int LIMIT = 2000000000);
  typedef struct {
    logic [ACTOR_W-1:0] actor;
    logic [TIME_W-1:0]  due;
  } slot_t;

  slot_t             slots[$];     // front first
  logic [TIME_W-1:0] base_time;
  rsp_t              awaited[$];   // response words still to arrive
  int errors, words_in, words_out;
  int n_pops, n_full, n_missing, n_empty, n_rebase, peak;

  function new();
    base_time = '0;
  endfunction

  function int pending();
    return awaited.size();
  endfunction

  function logic [ACTOR_W-1:0] pick_actor();
    if (slots.size() == 0) return ACTOR_W'($urandom_range(0, 1023));
    return slots[$urandom_range(0, slots.size() - 1)].actor;
  endfunction

  function void note_request(req_t w);
    rsp_t              r;
    slot_t             s;
    logic [TIME_W-1:0] when;
    int                pos;
    int                hit;
    r = '0;
    r.status = ST_OK;
    words_in++;
    case (w.command)
      CMD_INSERT: begin
        s.actor = w.actor_id;
        if (slots.size() == 0) begin
          base_time = '0;
          s.due = '0;
          slots.push_back(s);
        end else if (slots.size() >= CAP) begin
          r.status = ST_FULL;
          n_full++;
        end else begin
          if (base_time > TIME_W'(LIMIT)) begin
            foreach (slots[i]) slots[i].due = slots[i].due - base_time;
            base_time = '0;
            n_rebase++;
          end
          when = base_time + TIME_W'(w.delay);
          pos = 1;
          while (pos < slots.size() && slots[pos].due <= when) pos++;
          s.due = when;
          slots.insert(pos, s);
        end
        if (slots.size() > peak) peak = slots.size();
      end
      CMD_REMOVE: begin
        if (slots.size() == 0) begin
          r.status = ST_EMPTY;
          n_empty++;
        end else begin
          hit = -1;
          for (int i = 0; i < slots.size() && hit < 0; i++)
            if (slots[i].actor == w.actor_id) hit = i;
          if (hit >= 0) slots.delete(hit);
          else begin
            r.status = ST_NOT_FOUND;
            n_missing++;
          end
        end
      end
      CMD_POP: begin
        if (slots.size() == 0) begin
          r.status = ST_EMPTY;
          n_empty++;
        end else begin
          r.popped_actor = slots[0].actor;
          r.popped_valid = 1'b1;
          base_time = slots[0].due;
          void'(slots.pop_front());
          n_pops++;
        end
      end
      default: ;  // unused code: no effect, all-zero word
    endcase
    awaited.push_back(r);
  endfunction

  function void check_result(rsp_t got);
    rsp_t want;
    words_out++;
    if (awaited.size() == 0) begin
      $error("unexpected response word %h", got);
      errors++;
      return;
    end
    want = awaited.pop_front();
    if (got.popped_actor !== want.popped_actor) begin
      $error("popped_actor: expected %0d, got %0d", want.popped_actor, got.popped_actor);
      errors++;
    end
    if (got.popped_valid !== want.popped_valid) begin
      $error("popped_valid: expected %0d, got %0d", want.popped_valid, got.popped_valid);
      errors++;
    end
    if (got.status !== want.status) begin
      $error("status: expected %0d, got %0d", want.status, got.status);
      errors++;
    end
  endfunction
endclass

module tb_timed_turn_priority_queue;
  timeunit 1ns;
  timeprecision 1ps;

  // Block as specified: full capacity and the standard rebase threshold.
  localparam int CAPACITY     = 64;
  localparam int REBASE_LIMIT = 2000000000;

  // Command code the block ignores.
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  typedef enum int {MIX_FILL, MIX_EVEN, MIX_DRAIN} mix_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  bit   idle_on = 1'b1;  // cleared for the stretch with no idling

  ttpq_chan_if #(.payload_t(req_t)) req_if ();
  ttpq_chan_if #(.payload_t(rsp_t)) rsp_if ();

  timed_turn_priority_queue #(
    .CAPACITY    (CAPACITY),
    .REBASE_LIMIT(REBASE_LIMIT)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .req(req_if),
    .rsp(rsp_if)
  );

  turn_queue_tracker #(CAPACITY, REBASE_LIMIT) queue_model;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Response side: ready stalls about 14% of cycles while idling is on, driven on the falling edge.
  always @(negedge clk) begin
    rsp_if.ready <= !rst && (!idle_on || $urandom_range(0, 99) >= 14);
  end

  // Response words are sampled at the rising edge, before the block updates.
  always @(posedge clk) begin
    if (!rst && rsp_if.valid && rsp_if.ready) queue_model.check_result(rsp_if.payload);
  end

  function automatic req_t make_word(logic [1:0] cmd, int actor, int dly);
    req_t w;
    w.command  = cmd;
    w.actor_id = ACTOR_W'(actor);
    w.delay    = DELAY_W'(dly);
    return w;
  endfunction

  // Called at a falling edge; returns at the falling edge after the word is
  // taken. valid stays high between back-to-back words.
  task automatic send_word(req_t w);
    while (idle_on && $urandom_range(0, 99) < 14) begin
      req_if.valid <= 1'b0;
      @(negedge clk);
    end
    req_if.valid   <= 1'b1;
    req_if.payload <= w;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    queue_model.note_request(w);
    @(negedge clk);
  endtask

  // Hold the request side until every response word has come back.
  task automatic drain_queue();
    req_if.valid <= 1'b0;
    do @(negedge clk); while (queue_model.pending() != 0);
  endtask

  // Mostly short delays (ties, tight ordering), some extremes, rest anywhere.
  function automatic int pick_delay();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 20) return $urandom_range(0, 15);
    if (roll < 30) return 16'hFFFF;
    if (roll < 35) return 0;
    return $urandom_range(0, 65535);
  endfunction

  task automatic send_random(mix_t mix);
    int n_ins, n_rem, n_pop, roll, actor;
    case (mix)
      MIX_FILL:  begin n_ins = 85; n_rem = 5;  n_pop = 7;  end
      MIX_DRAIN: begin n_ins = 15; n_rem = 25; n_pop = 55; end
      default:   begin n_ins = 42; n_rem = 20; n_pop = 33; end
    endcase
    roll = $urandom_range(0, 99);
    if (roll < n_ins) begin
      // small pool gives duplicate actors
      actor = ($urandom_range(0, 99) < 30) ? $urandom_range(0, 7) : $urandom_range(0, 1023);
      send_word(make_word(CMD_INSERT, actor, pick_delay()));
    end else if (roll < n_ins + n_rem) begin
      // mostly actors that are queued, else likely absent
      actor = ($urandom_range(0, 99) < 65) ? int'(queue_model.pick_actor())
                                           : $urandom_range(0, 1023);
      send_word(make_word(CMD_REMOVE, actor, $urandom_range(0, 65535)));
    end else if (roll < n_ins + n_rem + n_pop) begin
      send_word(make_word(CMD_POP, $urandom_range(0, 1023), $urandom_range(0, 65535)));
    end else begin
      send_word(make_word(CMD_UNUSED, $urandom_range(0, 1023), $urandom_range(0, 65535)));
    end
  endtask

  initial begin
    req_if.valid   = 1'b0;
    req_if.payload = '0;
    rsp_if.ready   = 1'b0;
    queue_model    = new();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: empty-queue errors, unused code, insert into empty queue at
    // time zero, ties at equal times, extremes of id and delay, duplicates.
    send_word(make_word(CMD_POP,    0,    0));
    send_word(make_word(CMD_REMOVE, 0,    0));
    send_word(make_word(CMD_UNUSED, 1023, 16'hFFFF));
    send_word(make_word(CMD_INSERT, 1023, 16'hFFFF));
    send_word(make_word(CMD_INSERT, 0,    0));
    send_word(make_word(CMD_INSERT, 1023, 16'hFFFF));
    send_word(make_word(CMD_INSERT, 512,  0));
    send_word(make_word(CMD_INSERT, 341,  16'h8000));
    send_word(make_word(CMD_REMOVE, 777,  0));       // absent actor
    send_word(make_word(CMD_REMOVE, 1023, 0));       // first of two copies only
    send_word(make_word(CMD_UNUSED, 0,    0));
    send_word(make_word(CMD_POP,    0,    0));
    send_word(make_word(CMD_INSERT, 682,  1));
    send_word(make_word(CMD_POP,    0,    0));
    send_word(make_word(CMD_POP,    0,    0));
    send_word(make_word(CMD_POP,    0,    0));
    send_word(make_word(CMD_POP,    0,    0));
    send_word(make_word(CMD_POP,    0,    0));
    // Entry behind a later front ends up below the start time after the pop.
    send_word(make_word(CMD_INSERT, 1,    0));
    send_word(make_word(CMD_INSERT, 2,    16'hFFFF));
    send_word(make_word(CMD_POP,    0,    0));
    send_word(make_word(CMD_INSERT, 3,    10));
    send_word(make_word(CMD_POP,    0,    0));
    send_word(make_word(CMD_INSERT, 4,    5));
    drain_queue();

    // Random: 15 blocks of 100 words, cycling fill / even / drain mixes so the
    // queue reaches full and empty repeatedly. Blocks 6-8 run without idling.
    for (int blk = 0; blk < 15; blk++) begin
      idle_on = !(blk >= 6 && blk <= 8);
      for (int k = 0; k < 100; k++) send_random(mix_t'(blk % 3));
      if (blk == 4 || blk == 9) drain_queue();
    end
    idle_on = 1'b1;
    drain_queue();

    // Nothing left in flight; allow for a full rebase plus insert walk anyway.
    repeat (4 * CAPACITY + 10) @(posedge clk);
    if (queue_model.pending() != 0) begin
      $error("%0d response words never arrived", queue_model.pending());
      queue_model.errors++;
    end

    $display("Sent %0d commands, got %0d responses; queue peaked at %0d entries.",
             queue_model.words_in, queue_model.words_out, queue_model.peak);
    $display("Pops %0d, full %0d, empty %0d, not found %0d, rebases %0d.",
             queue_model.n_pops, queue_model.n_full, queue_model.n_empty,
             queue_model.n_missing, queue_model.n_rebase);
    if (queue_model.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Watchdog: well beyond a run with every command at full depth and stalls.
  initial begin
    #20ms;
    $display("Regression FAIL");
    $finish;
  end

endmodule
`default_nettype wire

// File: files.f
hdl/ttpq_pkg.sv
hdl/ttpq_chan_if.sv
hdl/timed_turn_priority_queue.sv
verif/tb_timed_turn_priority_queue.sv
